### sv/rwpe_pkg.sv
// ----------------------------------------------------------------------------
// rwpe_pkg: shared types and constants of the ring window prefetch/evict unit
// Field widths, action and command codes, register indexes, and the command
// and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rwpe_pkg;

  localparam int ACTION_W  = 2;
  localparam int STEP_W    = 8;
  localparam int SLOT_W    = 5;
  localparam int COMMAND_W = 2;
  localparam int TARGET_W  = 5;
  localparam int PRIO_W    = 6;
  localparam int COUNT_W   = 6;
  localparam int WIN_W     = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 6;
  localparam int CNT_W     = 7;
  localparam int MAG_W     = 8;

  // Largest ring that the count register can express
  localparam int RING_LIMIT = 63;
  // Most results reported per input item
  localparam int RES_LIMIT  = 64;
  // Restoring remainder steps, one per magnitude bit
  localparam int MOD_STEPS  = 8;

  localparam logic [ACTION_W-1:0] ACT_SEEK = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SLOT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ALL  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

  localparam logic [COMMAND_W-1:0] CMD_NOTHING = 2'd0;
  localparam logic [COMMAND_W-1:0] CMD_LOAD    = 2'd1;
  localparam logic [COMMAND_W-1:0] CMD_UNLOAD  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ITEM_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOAD_AHEAD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOAD_BEHIND  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_AHEAD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_BEHIND  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOADING_ON   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNLOADING_ON = 3'd6;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_ACCEPT,
    DP_MOD,
    DP_CUR,
    DP_TRIM_PTR,
    DP_FILL_PTR,
    DP_ZERO_PTR,
    DP_LOAD,
    DP_UNLOAD,
    DP_FINISH
  } dp_op_t;

  typedef enum logic [1:0] {
    SRC_FWD,
    SRC_BACK,
    SRC_SLOT
  } dp_src_t;

  typedef enum logic [1:0] {
    PR_CNT,
    PR_EVEN,
    PR_ODD,
    PR_SLOT
  } dp_psel_t;

  typedef struct packed {
    dp_op_t           op;
    dp_src_t          src;
    dp_psel_t         psel;
    logic [CNT_W-1:0] cnt;
  } dp_cmd_t;

  typedef struct packed {
    logic                ring_empty;
    logic [ACTION_W-1:0] action;
    logic                out_free;
    logic                unload_on;
    logic                load_on;
    logic                trim_go;
    logic                trim_alt;
    logic [CNT_W-1:0]    trim_n;
    logic                fill_full;
    logic [COUNT_W-1:0]  m;
    logic [WIN_W-1:0]    la;
    logic [WIN_W-1:0]    lb;
    logic                slot_ok;
    logic                prio_ok;
  } dp_stat_t;

  typedef struct packed {
    logic [COMMAND_W-1:0] command;
    logic [TARGET_W-1:0]  target;
    logic [PRIO_W-1:0]    priority_res;
    logic                 is_current;
    logic                 last;
  } out_item_t;

endpackage

### sv/rwpe_if.sv
// ----------------------------------------------------------------------------
// rwpe_if: request and result channels of the ring window prefetch/evict unit
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rwpe_in_if;
  logic                               valid;
  logic                               ready;
  logic [rwpe_pkg::ACTION_W-1:0]      action;
  logic signed [rwpe_pkg::STEP_W-1:0] step;
  logic [rwpe_pkg::SLOT_W-1:0]        slot;

  modport source (output valid, output action, output step, output slot, input ready);
  modport sink   (input valid, input action, input step, input slot, output ready);
endinterface

interface rwpe_out_if;
  logic                           valid;
  logic                           ready;
  logic [rwpe_pkg::COMMAND_W-1:0] command;
  logic [rwpe_pkg::TARGET_W-1:0]  target;
  logic [rwpe_pkg::PRIO_W-1:0]    priority_res;
  logic                           is_current;
  logic                           last;

  modport source (output valid, output command, output target, output priority_res,
                  output is_current, output last, input ready);
  modport sink   (input valid, input command, input target, input priority_res,
                  input is_current, input last, output ready);
endinterface

### sv/rwpe_dp.sv
// ----------------------------------------------------------------------------
// rwpe_dp: datapath of the ring window prefetch/evict unit
// Configuration registers, position, loaded flags, remainder unit, walk
// pointers, pending result and output register.
// ----------------------------------------------------------------------------
module rwpe_dp #(
  parameter int MAX_ITEMS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rwpe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rwpe_pkg::CFG_DAT_W-1:0]      cfg_data,
  input  logic [rwpe_pkg::ACTION_W-1:0]       in_action,
  input  logic signed [rwpe_pkg::STEP_W-1:0]  in_step,
  input  logic [rwpe_pkg::SLOT_W-1:0]         in_slot,
  input  rwpe_pkg::dp_cmd_t                   cmd,
  output rwpe_pkg::dp_stat_t                  stat,
  input  logic                                out_ready,
  output logic                                out_valid,
  output rwpe_pkg::out_item_t                 out_item
);

  localparam int CAP = (MAX_ITEMS < rwpe_pkg::RING_LIMIT) ? MAX_ITEMS : rwpe_pkg::RING_LIMIT;
  localparam int SW  = $clog2(CAP);

  // configuration
  logic [rwpe_pkg::COUNT_W-1:0] ic_r;
  logic [rwpe_pkg::WIN_W-1:0]   la_r, lb_r, ka_r, kb_r;
  logic                         lon_r, uon_r;

  // item state
  logic [SW-1:0]                 pos_r;
  logic [CAP-1:0]                loaded_r;
  logic [rwpe_pkg::ACTION_W-1:0] action_r;
  logic [rwpe_pkg::SLOT_W-1:0]   slot_r;
  logic [rwpe_pkg::MAG_W-1:0]    margin_r;
  logic [rwpe_pkg::MAG_W-1:0]    mag_r;
  logic                          neg_r;
  logic [SW-1:0]                 cur_r;
  logic [SW-1:0]                 fp_r, bp_r;
  logic [rwpe_pkg::CNT_W-1:0]    emit_cnt_r;
  logic                          pend_valid_r;
  rwpe_pkg::out_item_t           pend_r;
  logic                          out_valid_r;
  rwpe_pkg::out_item_t           out_item_r;

  logic [rwpe_pkg::COUNT_W-1:0] m, m_m1, cur6, s6, fw, bw, cur_val;
  logic [rwpe_pkg::CNT_W-1:0]   ksum, rest, trim_n;
  logic                         trim_on, trim_alt, fill_full, out_free;
  logic [rwpe_pkg::PRIO_W-1:0]  slot_prio, step_prio;
  logic                         prio_ok;
  logic [9:0]                   x;
  logic [13:0]                  msh;
  logic [2:0]                   shamt;
  logic [6:0]                   fa0;
  logic [7:0]                   ba0;
  logic [SW-1:0]                sel_idx, fp_adv, bp_adv;
  logic                         flag, is_step, hit, keep, out_load;
  rwpe_pkg::out_item_t          new_item, out_nxt;

  assign m    = (ic_r > rwpe_pkg::COUNT_W'(CAP)) ? rwpe_pkg::COUNT_W'(CAP) : ic_r;
  assign m_m1 = m - 6'd1;
  assign cur6 = 6'(cur_r);
  assign s6   = 6'(slot_r);
  assign out_free = !out_valid_r || out_ready;

  // trim window geometry
  assign ksum     = 7'(ka_r) + 7'(kb_r);
  assign trim_on  = uon_r && (m != 6'd0) && (ksum < 7'(m));
  assign rest     = 7'(m) - ksum - 7'd1;
  assign trim_alt = 9'(rest) >= {margin_r, 1'b0};
  assign trim_n   = trim_alt ? 7'({margin_r, 1'b0}) : rest;
  assign fill_full = (7'(la_r) + 7'(lb_r) + 7'd1) >= 7'(m);

  // priority of a single invalidated slot
  always_comb begin
    fw = (s6 >= cur6) ? s6 - cur6 : s6 + m - cur6;
    bw = (cur6 >= s6) ? cur6 - s6 : cur6 + m - s6;
    slot_prio = '0;
    prio_ok   = 1'b1;
    if (fill_full) begin
      if (fw < bw) begin
        slot_prio = (fw == 6'd0) ? 6'd0 : 6'({fw, 1'b0} - 7'd1);
      end else begin
        slot_prio = 6'({bw, 1'b0});
      end
    end else if (fw <= 6'(la_r)) begin
      slot_prio = (fw == 6'd0) ? 6'd0 : 6'({fw, 1'b0} - 7'd1);
    end else if (bw <= 6'(lb_r)) begin
      slot_prio = 6'({bw, 1'b0});
    end else begin
      prio_ok = 1'b0;
    end
  end

  always_comb begin
    stat.ring_empty = (m == 6'd0);
    stat.action     = action_r;
    stat.out_free   = out_free;
    stat.unload_on  = uon_r;
    stat.load_on    = lon_r;
    stat.trim_go    = trim_on && (trim_n != 7'd0);
    stat.trim_alt   = trim_alt;
    stat.trim_n     = trim_n;
    stat.fill_full  = fill_full;
    stat.m          = m;
    stat.la         = la_r;
    stat.lb         = lb_r;
    stat.slot_ok    = s6 < m;
    stat.prio_ok    = prio_ok;
  end

  // seek target before reduction, and the remainder step
  assign x     = 10'(pos_r) + ((in_action == rwpe_pkg::ACT_SEEK) ?
                                {{2{in_step[7]}}, in_step} : 10'd0);
  assign shamt = 3'(rwpe_pkg::MOD_STEPS - 1) - cmd.cnt[2:0];
  assign msh   = 14'(m) << shamt;
  assign cur_val = (neg_r && (mag_r != '0)) ? m - 6'(mag_r) : 6'(mag_r);
  assign fa0   = 7'(cur_r) + 7'(ka_r) + 7'd1;
  assign ba0   = 8'(cur_r) + 8'(m) - 8'(kb_r) - 8'd1;

  // walk step
  always_comb begin
    unique case (cmd.src)
      rwpe_pkg::SRC_FWD:  sel_idx = fp_r;
      rwpe_pkg::SRC_BACK: sel_idx = bp_r;
      default:            sel_idx = SW'(slot_r);
    endcase
    unique case (cmd.psel)
      rwpe_pkg::PR_CNT:  step_prio = 6'(cmd.cnt);
      rwpe_pkg::PR_EVEN: step_prio = 6'({cmd.cnt, 1'b0});
      rwpe_pkg::PR_ODD:  step_prio = 6'({cmd.cnt, 1'b1});
      default:           step_prio = slot_prio;
    endcase
    fp_adv  = (6'(fp_r) == m_m1) ? '0 : fp_r + 1'b1;
    bp_adv  = (bp_r == '0) ? SW'(m_m1) : bp_r - 1'b1;
    flag    = loaded_r[sel_idx];
    is_step = (cmd.op == rwpe_pkg::DP_LOAD) || (cmd.op == rwpe_pkg::DP_UNLOAD);
    hit     = (cmd.op == rwpe_pkg::DP_LOAD) ? !flag : flag;
    keep    = emit_cnt_r < 7'(rwpe_pkg::RES_LIMIT);

    new_item.command      = (cmd.op == rwpe_pkg::DP_LOAD) ? rwpe_pkg::CMD_LOAD
                                                          : rwpe_pkg::CMD_UNLOAD;
    new_item.target       = rwpe_pkg::TARGET_W'(sel_idx);
    new_item.priority_res = (cmd.op == rwpe_pkg::DP_LOAD) ? step_prio : '0;
    new_item.is_current   = (cmd.op == rwpe_pkg::DP_UNLOAD) && (sel_idx == cur_r);
    new_item.last         = 1'b0;

    out_load = 1'b0;
    out_nxt  = pend_r;
    if (is_step && hit && keep && pend_valid_r) begin
      out_load = 1'b1;
    end else if (cmd.op == rwpe_pkg::DP_FINISH) begin
      out_load = 1'b1;
      if (pend_valid_r) begin
        out_nxt.last = 1'b1;
      end else begin
        out_nxt = '{command: rwpe_pkg::CMD_NOTHING, target: '0, priority_res: '0,
                    is_current: 1'b0, last: 1'b1};
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ic_r  <= '0;
      la_r  <= 5'd1;
      lb_r  <= 5'd1;
      ka_r  <= 5'd2;
      kb_r  <= 5'd2;
      lon_r <= 1'b1;
      uon_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rwpe_pkg::REG_ITEM_COUNT:   ic_r  <= cfg_data;
        rwpe_pkg::REG_LOAD_AHEAD:   la_r  <= 5'(cfg_data);
        rwpe_pkg::REG_LOAD_BEHIND:  lb_r  <= 5'(cfg_data);
        rwpe_pkg::REG_KEEP_AHEAD:   ka_r  <= 5'(cfg_data);
        rwpe_pkg::REG_KEEP_BEHIND:  kb_r  <= 5'(cfg_data);
        rwpe_pkg::REG_LOADING_ON:   lon_r <= cfg_data[0];
        rwpe_pkg::REG_UNLOADING_ON: uon_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      loaded_r     <= '0;
      emit_cnt_r   <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.op)
        rwpe_pkg::DP_ACCEPT: begin
          emit_cnt_r   <= '0;
          pend_valid_r <= 1'b0;
          if ((in_action == rwpe_pkg::ACT_SEEK) && (m == 6'd0)) begin
            pos_r <= '0;
          end
        end
        rwpe_pkg::DP_CUR: begin
          if (action_r == rwpe_pkg::ACT_SEEK) begin
            pos_r <= SW'(cur_val);
          end
        end
        rwpe_pkg::DP_LOAD, rwpe_pkg::DP_UNLOAD: begin
          if (hit) begin
            loaded_r[sel_idx] <= (cmd.op == rwpe_pkg::DP_LOAD);
            if (keep) begin
              pend_valid_r <= 1'b1;
              emit_cnt_r   <= emit_cnt_r + 7'd1;
            end
          end
        end
        rwpe_pkg::DP_FINISH: pend_valid_r <= 1'b0;
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r <= out_nxt;
    end
    unique case (cmd.op)
      rwpe_pkg::DP_ACCEPT: begin
        action_r <= in_action;
        slot_r   <= in_slot;
        margin_r <= in_step[7] ? 8'(~in_step + 8'sd1) : 8'(in_step);
        neg_r    <= x[9];
        mag_r    <= x[9] ? 8'(-x) : 8'(x);
      end
      rwpe_pkg::DP_MOD: begin
        if (14'(mag_r) >= msh) begin
          mag_r <= mag_r - 8'(msh);
        end
      end
      rwpe_pkg::DP_CUR: cur_r <= SW'(cur_val);
      rwpe_pkg::DP_TRIM_PTR: begin
        fp_r <= (fa0 >= 7'(m)) ? SW'(fa0 - 7'(m)) : SW'(fa0);
        bp_r <= (ba0 >= 8'(m)) ? SW'(ba0 - 8'(m)) : SW'(ba0);
      end
      rwpe_pkg::DP_FILL_PTR: begin
        bp_r <= cur_r;
        fp_r <= (cur6 == m_m1) ? '0 : cur_r + 1'b1;
      end
      rwpe_pkg::DP_ZERO_PTR: fp_r <= '0;
      rwpe_pkg::DP_LOAD, rwpe_pkg::DP_UNLOAD: begin
        if (hit && keep) begin
          pend_r <= new_item;
        end
        if (cmd.src == rwpe_pkg::SRC_FWD) begin
          fp_r <= fp_adv;
        end else if (cmd.src == rwpe_pkg::SRC_BACK) begin
          bp_r <= bp_adv;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_step_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (is_step || (cmd.op == rwpe_pkg::DP_FINISH)) |-> (!out_valid_r || out_ready))
    else $error("walk step issued while output register is blocked");

  a_finish_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == rwpe_pkg::DP_FINISH) |=> (!pend_valid_r && out_valid_r))
    else $error("final result not moved to output");

  a_index_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    is_step |-> (6'(sel_idx) < m))
    else $error("walk index outside ring");

  a_pend_counted: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (emit_cnt_r != 7'd0))
    else $error("pending result without emission count");

endmodule

### sv/rwpe_ctrl.sv
// ----------------------------------------------------------------------------
// rwpe_ctrl: controller of the ring window prefetch/evict unit
// Sequences remainder, trim, unload-all, fill and invalidate walks one step per cycle unless the output is blocked.
// ----------------------------------------------------------------------------
module rwpe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output rwpe_pkg::dp_cmd_t  cmd,
  input  rwpe_pkg::dp_stat_t stat
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_MOD       = 4'd1;
  localparam logic [3:0] S_CUR       = 4'd2;
  localparam logic [3:0] S_TRIM_PTR  = 4'd3;
  localparam logic [3:0] S_TRIM      = 4'd4;
  localparam logic [3:0] S_FILL_PTR  = 4'd5;
  localparam logic [3:0] S_FILL_ALT  = 4'd6;
  localparam logic [3:0] S_FILL_BACK = 4'd7;
  localparam logic [3:0] S_FILL_FWD  = 4'd8;
  localparam logic [3:0] S_ZERO      = 4'd9;
  localparam logic [3:0] S_UNALL     = 4'd10;
  localparam logic [3:0] S_INV_UN    = 4'd11;
  localparam logic [3:0] S_INV_LD    = 4'd12;
  localparam logic [3:0] S_FIN       = 4'd13;

  logic [3:0]                 state_r, state_nxt;
  logic [rwpe_pkg::CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;

  assign cnt_inc  = cnt_r + 7'd1;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.op    = rwpe_pkg::DP_NOP;
    cmd.src   = rwpe_pkg::SRC_FWD;
    cmd.psel  = rwpe_pkg::PR_CNT;
    cmd.cnt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = rwpe_pkg::DP_ACCEPT;
          cnt_nxt   = '0;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (stat.ring_empty || (stat.action == rwpe_pkg::ACT_NONE)) begin
          state_nxt = S_FIN;
        end else begin
          cmd.op = rwpe_pkg::DP_MOD;
          if (cnt_r == 7'(rwpe_pkg::MOD_STEPS - 1)) begin
            state_nxt = S_CUR;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      end
      S_CUR: begin
        cmd.op = rwpe_pkg::DP_CUR;
        unique case (stat.action)
          rwpe_pkg::ACT_SEEK: state_nxt = S_TRIM_PTR;
          rwpe_pkg::ACT_SLOT: state_nxt = S_INV_UN;
          rwpe_pkg::ACT_ALL:  state_nxt = S_ZERO;
          default:            state_nxt = S_FIN;
        endcase
      end
      S_TRIM_PTR: begin
        cmd.op    = rwpe_pkg::DP_TRIM_PTR;
        cnt_nxt   = '0;
        state_nxt = stat.trim_go ? S_TRIM : S_FILL_PTR;
      end
      S_TRIM: begin
        if (stat.out_free) begin
          cmd.op  = rwpe_pkg::DP_UNLOAD;
          // alternate ahead and behind edges of the keep window when trim_alt is set, else ahead only
          cmd.src = (stat.trim_alt && cnt_r[0]) ? rwpe_pkg::SRC_BACK : rwpe_pkg::SRC_FWD;
          if (cnt_inc == stat.trim_n) begin
            state_nxt = S_FILL_PTR;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      end
      S_FILL_PTR: begin
        cmd.op  = rwpe_pkg::DP_FILL_PTR;
        cnt_nxt = '0;
        priority if (!stat.load_on) begin
          state_nxt = S_FIN;
        end else if (stat.fill_full) begin
          state_nxt = S_FILL_ALT;
        end else begin
          state_nxt = S_FILL_BACK;
        end
      end
      S_FILL_ALT: begin
        if (stat.out_free) begin
          cmd.op  = rwpe_pkg::DP_LOAD;
          cmd.src = cnt_r[0] ? rwpe_pkg::SRC_FWD : rwpe_pkg::SRC_BACK;
          if (cnt_inc == 7'(stat.m)) begin
            state_nxt = S_FIN;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      end
      S_FILL_BACK: begin
        if (stat.out_free) begin
          cmd.op   = rwpe_pkg::DP_LOAD;
          cmd.src  = rwpe_pkg::SRC_BACK;
          cmd.psel = rwpe_pkg::PR_EVEN;
          if (cnt_r == 7'(stat.lb)) begin
            cnt_nxt   = '0;
            state_nxt = (stat.la == '0) ? S_FIN : S_FILL_FWD;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      end
      S_FILL_FWD: begin
        if (stat.out_free) begin
          cmd.op   = rwpe_pkg::DP_LOAD;
          cmd.src  = rwpe_pkg::SRC_FWD;
          cmd.psel = rwpe_pkg::PR_ODD;
          if (cnt_inc == 7'(stat.la)) begin
            state_nxt = S_FIN;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      end
      S_ZERO: begin
        cmd.op    = rwpe_pkg::DP_ZERO_PTR;
        cnt_nxt   = '0;
        state_nxt = stat.unload_on ? S_UNALL : S_FILL_PTR;
      end
      S_UNALL: begin
        if (stat.out_free) begin
          cmd.op = rwpe_pkg::DP_UNLOAD;
          if (cnt_inc == 7'(stat.m)) begin
            state_nxt = S_FILL_PTR;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      end
      S_INV_UN: begin
        priority if (!stat.slot_ok) begin
          state_nxt = S_FIN;
        end else if (!stat.unload_on) begin
          state_nxt = S_INV_LD;
        end else if (stat.out_free) begin
          cmd.op    = rwpe_pkg::DP_UNLOAD;
          cmd.src   = rwpe_pkg::SRC_SLOT;
          state_nxt = S_INV_LD;
        end
      end
      S_INV_LD: begin
        priority if (!(stat.load_on && stat.prio_ok)) begin
          state_nxt = S_FIN;
        end else if (stat.out_free) begin
          cmd.op    = rwpe_pkg::DP_LOAD;
          cmd.src   = rwpe_pkg::SRC_SLOT;
          cmd.psel  = rwpe_pkg::PR_SLOT;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.op    = rwpe_pkg::DP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == rwpe_pkg::DP_ACCEPT) |=> (state_r == S_MOD))
    else $error("accept did not start remainder sequence");

  a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == rwpe_pkg::DP_FINISH) |=> in_ready)
    else $error("finish did not return to idle");

  a_mod_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD) |-> (cnt_r < 7'(rwpe_pkg::MOD_STEPS)))
    else $error("remainder step count overrun");

endmodule

### sv/ring_window_prefetch_evict_unit.sv
// ----------------------------------------------------------------------------
// ring_window_prefetch_evict_unit: ring window prefetch/evict controller
// Tracks a position on a ring of slots with a loaded flag per slot and
// issues load/unload commands for seeks and invalidates.
// ----------------------------------------------------------------------------
// One request is handled at a time. Each request passes through an accept
// step, the restoring remainder unit that reduces the new position modulo
// the ring size, setup steps, then the trim, unload or fill walk that visits
// the slots (a single flag is read and written per cycle), and a last step
// that delivers the final result. A walk step pauses while the output
// register holds an untaken result. Results of a request arrive in order,
// the last one flagged; a request that causes no command yields a single
// "nothing to do" result. Registers may be written only while no request is
// in flight.
// ----------------------------------------------------------------------------
module ring_window_prefetch_evict_unit #(
  parameter int MAX_ITEMS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rwpe_in_if.sink                        in_if,
  rwpe_out_if.source                     out_if,
  input  logic                           cfg_we,
  input  logic [rwpe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rwpe_pkg::CFG_DAT_W-1:0] cfg_data
);

  rwpe_pkg::dp_cmd_t   cmd;
  rwpe_pkg::dp_stat_t  stat;
  rwpe_pkg::out_item_t out_item;
  logic                in_ready;
  logic                out_valid;

  rwpe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  rwpe_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_action (in_if.action),
    .in_step   (in_if.step),
    .in_slot   (in_if.slot),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_if.ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  assign in_if.ready         = in_ready;
  assign out_if.valid        = out_valid;
  assign out_if.command      = out_item.command;
  assign out_if.target       = out_item.target;
  assign out_if.priority_res = out_item.priority_res;
  assign out_if.is_current   = out_item.is_current;
  assign out_if.last         = out_item.last;

endmodule

### dv/ring_window_prefetch_evict_unit_test.sv
// ----------------------------------------------------------------------------
// ring_window_prefetch_evict_unit_test: self-checking bench for the ring window
// prefetch/evict unit
// Sends seek and invalidate requests with random gaps and stalls the command
// channel at random. A cycle-free predictor tracks the ring position, the
// window registers and the per-slot loaded flags, and every command is checked
// in order against it. Register settings change between drained phases.
// ----------------------------------------------------------------------------
module ring_window_prefetch_evict_unit_test;
  import rwpe_pkg::*;

  localparam int RING_SLOTS = 32;

  typedef struct {
    logic [ACTION_W-1:0]      action;
    logic signed [STEP_W-1:0] step;
    logic [SLOT_W-1:0]        slot;
  } request_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  rwpe_in_if  in_if ();
  rwpe_out_if out_if ();

  ring_window_prefetch_evict_unit #(.MAX_ITEMS(RING_SLOTS)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state: registers, ring position and loaded flags
  logic [COUNT_W-1:0] ring_items;
  logic [WIN_W-1:0]   ahead_load, behind_load, ahead_keep, behind_keep;
  logic               load_enable, unload_enable;
  logic [SLOT_W-1:0]  cur_pos;
  logic               slot_loaded [RING_SLOTS];

  out_item_t cmd_batch[$];
  out_item_t cmd_expected[$];
  out_item_t next_cmd;
  request_t  pending_reqs[$];
  request_t  driven_req;
  int        req_on_bus;
  int        errors;
  int        send_gap;
  int        sink_gap;
  bit        no_idle;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  task automatic record_cmd(logic [COMMAND_W-1:0] c, int tgt, int prio, bit at_cur);
    out_item_t r;
    if (cmd_batch.size() < RES_LIMIT) begin
      r.command      = c;
      r.target       = tgt[TARGET_W-1:0];
      r.priority_res = prio[PRIO_W-1:0];
      r.is_current   = at_cur;
      r.last         = 1'b0;
      cmd_batch.push_back(r);
    end
  endtask

  task automatic load_slot(int s, int prio);
    if (!slot_loaded[s]) begin
      slot_loaded[s] = 1'b1;
      record_cmd(CMD_LOAD, s, prio, 1'b0);
    end
  endtask

  task automatic evict_slot(int s, int cur);
    if (slot_loaded[s]) begin
      slot_loaded[s] = 1'b0;
      record_cmd(CMD_UNLOAD, s, 0, s == cur);
    end
  endtask

  // Load the window around cur, nearest first on each side
  task automatic fill_window(int m, int cur);
    int la, lb;
    la = ahead_load;
    lb = behind_load;
    if (!load_enable || m == 0) return;
    if (la + lb + 1 >= m) begin
      // window covers the whole ring: alternate behind and ahead
      for (int i = 0; i < m; i++) begin
        if (i % 2 != 0) load_slot((cur + i / 2 + 1) % m, i);
        else load_slot((cur + m - i / 2) % m, i);
      end
    end else begin
      for (int i = 0; i <= lb; i++) load_slot((cur + m - i) % m, 2 * i);
      for (int i = 0; i < la; i++) load_slot((cur + i + 1) % m, 2 * i + 1);
    end
  endtask

  task automatic predict_commands(request_t rq);
    int m, cur, st, margin, rest, fw, bw, prio, ka, kb, la, lb, s;
    bit in_window;
    m  = (ring_items > RING_SLOTS) ? RING_SLOTS : ring_items;
    cur = (m != 0) ? cur_pos % m : 0;
    ka = ahead_keep;
    kb = behind_keep;
    la = ahead_load;
    lb = behind_load;
    cmd_batch.delete();
    case (rq.action)
      ACT_SEEK: begin
        if (m == 0) begin
          cur_pos = '0;
        end else begin
          st = rq.step;
          cur = ((cur + st) % m + m) % m;
          cur_pos = cur[SLOT_W-1:0];
          margin = (st < 0) ? -st : st;
          // drop slots that left the keep window: margin per side, or the rest ahead
          if (unload_enable && ka + kb < m) begin
            rest = m - ka - kb - 1;
            if (rest >= 2 * margin) begin
              for (int i = 0; i < margin; i++) begin
                evict_slot((cur + ka + i + 1) % m, cur);
                evict_slot((cur + m - (kb + i + 1)) % m, cur);
              end
            end else begin
              for (int i = ka; i < ka + rest; i++) evict_slot((cur + i + 1) % m, cur);
            end
          end
          fill_window(m, cur);
        end
      end
      ACT_SLOT: begin
        s = rq.slot;
        if (s < m) begin
          if (unload_enable) evict_slot(s, cur);
          if (load_enable && !slot_loaded[s]) begin
            fw = (m + s - cur) % m;
            bw = (m + cur - s) % m;
            in_window = 1'b1;
            prio = 0;
            if (la + lb + 1 >= m) prio = (fw < bw) ? ((fw != 0) ? 2 * fw - 1 : 0) : 2 * bw;
            else if (fw <= la) prio = (fw != 0) ? 2 * fw - 1 : 0;
            else if (bw <= lb) prio = 2 * bw;
            else in_window = 1'b0;
            if (in_window) load_slot(s, prio);
          end
        end
      end
      ACT_ALL: begin
        if (m != 0) begin
          if (unload_enable) begin
            for (int i = 0; i < m; i++) evict_slot(i, cur);
          end
          fill_window(m, cur);
        end
      end
      default: begin
      end
    endcase
    if (cmd_batch.size() == 0) record_cmd(CMD_NOTHING, 0, 0, 1'b0);
    cmd_batch[cmd_batch.size() - 1].last = 1'b1;
    foreach (cmd_batch[i]) cmd_expected.push_back(cmd_batch[i]);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      if (errors <= 200)
        $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // Request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_commands(driven_req);
        req_on_bus--;
        send_gap = pick_gap();
      end
      // hold the payload until the transfer
      if (in_if.ready || !in_if.valid) begin
        if (send_gap > 0) begin
          send_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          driven_req = pending_reqs.pop_front();
          req_on_bus++;
          in_if.valid  <= 1'b1;
          in_if.action <= driven_req.action;
          in_if.step   <= driven_req.step;
          in_if.slot   <= driven_req.slot;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Command monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (cmd_expected.size() == 0) begin
          errors++;
          if (errors <= 200)
            $display("%0t: command mismatch: expected none actual %0d target %0d",
                     $time, out_if.command, out_if.target);
        end else begin
          next_cmd = cmd_expected.pop_front();
          check_field("command", next_cmd.command, out_if.command);
          check_field("target", next_cmd.target, out_if.target);
          check_field("priority_res", next_cmd.priority_res, out_if.priority_res);
          check_field("is_current", next_cmd.is_current, out_if.is_current);
          check_field("last", next_cmd.last, out_if.last);
        end
        sink_gap = pick_gap();
      end else if (!out_if.valid && $urandom_range(15) == 0) begin
        sink_gap = pick_gap();
      end
      if (sink_gap > 0) begin
        sink_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic add_req(logic [ACTION_W-1:0] act, int st, int s);
    request_t rq;
    rq.action = act;
    rq.step   = STEP_W'(st);
    rq.slot   = SLOT_W'(s);
    pending_reqs.push_back(rq);
  endtask

  // Let every pending transfer and command drain, then settle
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || req_on_bus != 0 || cmd_expected.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic apply_settings(input int vals[7]);
    logic [CFG_IDX_W-1:0] reg_ids [7];
    reg_ids = '{REG_ITEM_COUNT, REG_LOAD_AHEAD, REG_LOAD_BEHIND, REG_KEEP_AHEAD,
                REG_KEEP_BEHIND, REG_LOADING_ON, REG_UNLOADING_ON};
    for (int i = 0; i < 7; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= reg_ids[i];
      cfg_data  <= vals[i][CFG_DAT_W-1:0];
      case (reg_ids[i])
        REG_ITEM_COUNT:   ring_items    = vals[i][COUNT_W-1:0];
        REG_LOAD_AHEAD:   ahead_load    = vals[i][WIN_W-1:0];
        REG_LOAD_BEHIND:  behind_load   = vals[i][WIN_W-1:0];
        REG_KEEP_AHEAD:   ahead_keep    = vals[i][WIN_W-1:0];
        REG_KEEP_BEHIND:  behind_keep   = vals[i][WIN_W-1:0];
        REG_LOADING_ON:   load_enable   = vals[i][0];
        REG_UNLOADING_ON: unload_enable = vals[i][0];
        default: begin
        end
      endcase
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_settings(output int vals[7]);
    int r, junk;
    r = $urandom_range(99);
    if (r < 5) vals[0] = 0;
    else if (r < 10) vals[0] = 1;
    else if (r < 15) vals[0] = 2;
    else if (r < 27) vals[0] = RING_SLOTS;
    else if (r < 34) vals[0] = $urandom_range(63, RING_SLOTS + 1);
    else vals[0] = $urandom_range(RING_SLOTS - 1, 3);
    for (int i = 1; i < 5; i++) begin
      r = $urandom_range(99);
      if (r < 50) vals[i] = $urandom_range(3);
      else if (r < 88) vals[i] = $urandom_range(31);
      else vals[i] = 31;
    end
    vals[5] = ($urandom_range(9) != 0);
    vals[6] = ($urandom_range(9) != 0);
    // set unused upper data bits now and then
    for (int i = 1; i < 7; i++) begin
      junk = $urandom_range(1) ? $urandom_range(63) : 0;
      vals[i] = vals[i] | (junk & ((i < 5) ? 32 : 62));
    end
  endtask

  task automatic add_random_reqs(int n);
    int r, m, st;
    m = (ring_items > RING_SLOTS) ? RING_SLOTS : ring_items;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 60) begin
        st = $urandom_range(99);
        if (st < 55) st = $urandom_range(8) - 4;
        else if (st < 80) st = $urandom_range(40) - 20;
        else st = $urandom_range(255);
        add_req(ACT_SEEK, st, $urandom_range(31));
      end else if (r < 78) begin
        add_req(ACT_SLOT, $urandom_range(255),
                (m > 0 && $urandom_range(3) != 0) ? $urandom_range(m - 1) : $urandom_range(31));
      end else if (r < 92) begin
        add_req(ACT_ALL, $urandom_range(255), $urandom_range(31));
      end else begin
        add_req(ACT_NONE, $urandom_range(255), $urandom_range(31));
      end
    end
  endtask

  initial begin
    int vals[7];
    in_if.valid   = 1'b0;
    in_if.action  = ACT_SEEK;
    in_if.step    = '0;
    in_if.slot    = '0;
    out_if.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_ITEM_COUNT;
    cfg_data      = '0;
    rst_n         = 1'b0;
    errors        = 0;
    req_on_bus    = 0;
    no_idle       = 1'b0;
    ring_items    = '0;
    ahead_load    = 5'd1;
    behind_load   = 5'd1;
    ahead_keep    = 5'd2;
    behind_keep   = 5'd2;
    load_enable   = 1'b1;
    unload_enable = 1'b1;
    cur_pos       = '0;
    foreach (slot_loaded[i]) slot_loaded[i] = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty ring: nothing to do for any action
    add_req(ACT_SEEK, 5, 0);
    add_req(ACT_SLOT, 0, 0);
    add_req(ACT_ALL, 0, 0);
    add_req(ACT_NONE, -1, 31);
    wait_idle();

    // Small ring with the reset windows; step extremes and slot cases
    apply_settings('{8, 1, 1, 2, 2, 1, 1});
    add_req(ACT_ALL, 0, 0);
    add_req(ACT_SEEK, 1, 0);
    add_req(ACT_SEEK, -1, 0);
    add_req(ACT_SEEK, 0, 0);
    add_req(ACT_SEEK, 127, 0);
    add_req(ACT_SEEK, -128, 0);
    add_req(ACT_SLOT, 0, 7);
    add_req(ACT_SLOT, 0, 0);
    add_req(ACT_SLOT, 0, 3);
    add_req(ACT_SLOT, 0, 20);
    add_req(ACT_SLOT, 0, 31);
    add_req(ACT_NONE, 0, 0);
    wait_idle();

    // Shrink the ring under the current position
    apply_settings('{5, 1, 1, 2, 2, 1, 1});
    add_req(ACT_SLOT, 0, 4);
    add_req(ACT_ALL, 0, 0);
    add_req(ACT_SEEK, 0, 0);
    wait_idle();

    // Oversized count with the widest windows
    apply_settings('{40, 31, 31, 31, 31, 1, 1});
    add_req(ACT_ALL, 0, 0);
    add_req(ACT_SEEK, 3, 0);
    add_req(ACT_SEEK, -100, 0);
    wait_idle();

    apply_settings('{32, 0, 0, 0, 0, 0, 1});
    add_req(ACT_SEEK, 10, 0);
    wait_idle();
    apply_settings('{32, 2, 2, 1, 1, 1, 0});
    add_req(ACT_SEEK, 5, 0);
    wait_idle();

    for (int ph = 0; ph < 9; ph++) begin
      random_settings(vals);
      if (ph == 0) vals = '{32, 31, 31, 31, 31, 1, 1};
      else if (ph == 1) vals = '{32, 0, 0, 0, 0, 1, 1};
      else if (ph == 2) vals[0] = 1;
      no_idle = (ph == 4);
      apply_settings(vals);
      add_random_reqs(23);
      // in every third phase, pause the sender until every command has come back
      if (ph % 3 == 0) wait_idle();
      add_random_reqs(23);
      wait_idle();
    end

    if (errors == 0) begin
      $display("PASS ring_window_prefetch_evict_unit");
    end else begin
      $display("FAIL ring_window_prefetch_evict_unit");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("FAIL ring_window_prefetch_evict_unit");
    $finish;
  end

endmodule

### filelist.f
sv/rwpe_pkg.sv
sv/rwpe_if.sv
sv/rwpe_dp.sv
sv/rwpe_ctrl.sv
sv/ring_window_prefetch_evict_unit.sv
dv/ring_window_prefetch_evict_unit_test.sv
